// ===== sv/kscl_pkg.sv =====
// Shared constants, types and register codes for the keypad scanner code lock
`default_nettype none

package kscl_pkg;

    // Keypad and code geometry
    localparam int ROWS          = 4;
    localparam int COLS          = 4;
    localparam int HISTORY_DEPTH = 4;
    localparam int CODE_LENGTH   = 12;

    // Derived sizes
    localparam int KEY_BITS  = ROWS * COLS;
    localparam int ROW_IDX_W = $clog2(ROWS);
    localparam int HIST_N    = HISTORY_DEPTH - 1;
    localparam int STEP_W    = $clog2(CODE_LENGTH + 2);
    localparam int CODE_SLOTS = 16;

    // Fixed field widths
    localparam int CNT_W      = 16;
    localparam int COL_IN_W   = 4;
    localparam int ROW_OUT_W  = 4;
    localparam int KEYS_OUT_W = 16;
    localparam int POS_OUT_W  = 4;
    localparam int KEY_IDX_W  = 4;
    localparam int CODE_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Lock step codes
    localparam logic [STEP_W-1:0] STEP_CORRECT = STEP_W'(CODE_LENGTH);
    localparam logic [STEP_W-1:0] STEP_ERROR   = STEP_W'(CODE_LENGTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_KEYS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_KEY     = 2'd3;

    // Register reset values
    localparam logic [CNT_W-1:0]     SCAN_INTERVAL_RST = 16'd20;
    localparam logic [CNT_W-1:0]     LOCKOUT_TIME_RST  = 16'd500;
    localparam logic [CODE_W-1:0]    CODE_KEYS_RST     = 48'd264487514688150;
    localparam logic [KEY_IDX_W-1:0] CLEAR_KEY_RST     = 4'd3;

    // One scanned tick on its way from the scanner to the lock sequencer
    typedef struct packed {
        logic [ROWS-1:0]     row_pins;
        logic [KEY_BITS-1:0] matrix;
        logic                taken;
    } tick_entry_t;

endpackage

`default_nettype wire

// ===== sv/keypad_scan_code_lock_core.sv =====
// Top level of the keypad scanner code lock: configuration registers and wiring
`default_nettype none

// One input transfer is one timer tick carrying the column pin levels; the block
// takes a tick every clock cycle unless the queue is full. The scanner updates
// the row drive, key matrix, debounce history and lockout timers in the cycle it
// takes the tick and writes the outcome into a two-entry queue; the sequencer
// pops one entry a cycle when its result register is empty or the output is not
// stalled and registers it, so a result passes through the queue and then the
// result register before it is presented. Stalling the output fills the queue,
// and the input stalls only when both queue entries are occupied. Configuration
// writes take effect at once and are meant to be made while no tick is in flight.
module keypad_scan_code_lock_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [kscl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kscl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [kscl_pkg::COL_IN_W-1:0]    column_levels,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [kscl_pkg::ROW_OUT_W-1:0]        row_drive_n,
    output logic [kscl_pkg::KEYS_OUT_W-1:0]       keys_now,
    output logic [kscl_pkg::POS_OUT_W-1:0]        code_position,
    output logic                                  unlocked,
    output logic                                  press_taken
);

    logic [kscl_pkg::CNT_W-1:0]     scan_interval_reg;
    logic [kscl_pkg::CNT_W-1:0]     lockout_time_reg;
    logic [kscl_pkg::CODE_W-1:0]    code_keys_reg;
    logic [kscl_pkg::KEY_IDX_W-1:0] clear_key_reg;

    kscl_pkg::tick_entry_t push_entry;
    kscl_pkg::tick_entry_t pop_entry;
    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_valid;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_interval_reg <= kscl_pkg::SCAN_INTERVAL_RST;
            lockout_time_reg  <= kscl_pkg::LOCKOUT_TIME_RST;
            code_keys_reg     <= kscl_pkg::CODE_KEYS_RST;
            clear_key_reg     <= kscl_pkg::CLEAR_KEY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kscl_pkg::CFG_SCAN_INTERVAL:
                    scan_interval_reg <= cfg_wdata[kscl_pkg::CNT_W-1:0];
                kscl_pkg::CFG_LOCKOUT_TIME:
                    lockout_time_reg  <= cfg_wdata[kscl_pkg::CNT_W-1:0];
                kscl_pkg::CFG_CODE_KEYS:
                    code_keys_reg     <= cfg_wdata[kscl_pkg::CODE_W-1:0];
                kscl_pkg::CFG_CLEAR_KEY:
                    clear_key_reg     <= cfg_wdata[kscl_pkg::KEY_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_stall = q_full;

    kscl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (q_full),
        .column_levels (column_levels),
        .scan_interval (scan_interval_reg),
        .lockout_time  (lockout_time_reg),
        .push_entry    (push_entry),
        .push          (push)
    );

    kscl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    kscl_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (pop_entry),
        .pop           (pop),
        .code_keys     (code_keys_reg),
        .clear_key     (clear_key_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_drive_n   (row_drive_n),
        .keys_now      (keys_now),
        .code_position (code_position),
        .unlocked      (unlocked),
        .press_taken   (press_taken)
    );

endmodule

`default_nettype wire

// ===== sv/kscl_front.sv =====
// Row scanner, debounce history, re-arm and lockout timing
`default_nettype none

module kscl_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [kscl_pkg::COL_IN_W-1:0]  column_levels,
    input  wire logic [kscl_pkg::CNT_W-1:0]     scan_interval,
    input  wire logic [kscl_pkg::CNT_W-1:0]     lockout_time,
    output kscl_pkg::tick_entry_t               push_entry,
    output logic                                push
);

    logic [kscl_pkg::CNT_W-1:0]     scan_elapsed_reg, scan_elapsed_next;
    logic [kscl_pkg::CNT_W-1:0]     hold_elapsed_reg, hold_elapsed_next;
    logic [kscl_pkg::ROW_IDX_W-1:0] scan_row_reg, scan_row_next;
    logic [kscl_pkg::ROWS-1:0]      row_pins_reg, row_pins_next;
    logic [kscl_pkg::KEY_BITS-1:0]  key_matrix_reg, key_matrix_next;
    logic [kscl_pkg::KEY_BITS-1:0]  hist_reg [kscl_pkg::HIST_N];
    logic                           rearmed_reg, rearmed_next;
    logic                           taken;

    assign push = in_valid && !in_stall;

    // Work out the state after this tick
    always_comb
    begin
        logic [kscl_pkg::CNT_W-1:0]             se_inc;
        logic [kscl_pkg::CNT_W-1:0]             he_inc;
        logic [kscl_pkg::ROW_IDX_W-1:0]         row_after;
        logic [kscl_pkg::COLS+kscl_pkg::COL_IN_W-1:0] cols_ext;
        logic                                   stable;
        logic                                   rearm_now;

        se_inc    = (scan_elapsed_reg == '1) ? scan_elapsed_reg : scan_elapsed_reg + 1'b1;
        he_inc    = (hold_elapsed_reg == '1) ? hold_elapsed_reg : hold_elapsed_reg + 1'b1;
        cols_ext  = (kscl_pkg::COLS + kscl_pkg::COL_IN_W)'(column_levels);
        row_after = (scan_row_reg == kscl_pkg::ROW_IDX_W'(kscl_pkg::ROWS - 1))
                    ? '0 : scan_row_reg + 1'b1;

        scan_elapsed_next = se_inc;
        scan_row_next     = scan_row_reg;
        row_pins_next     = row_pins_reg;
        key_matrix_next   = key_matrix_reg;

        // Scan: capture the current row, release it, drive the next one
        if (se_inc >= scan_interval)
        begin
            scan_elapsed_next = '0;
            scan_row_next     = row_after;
            for (int r = 0; r < kscl_pkg::ROWS; r++)
            begin
                if (kscl_pkg::ROW_IDX_W'(r) == scan_row_reg)
                begin
                    for (int c = 0; c < kscl_pkg::COLS; c++)
                    begin
                        key_matrix_next[r*kscl_pkg::COLS + c] = !cols_ext[c];
                    end
                    row_pins_next[r] = 1'b1;
                end
            end
            for (int r = 0; r < kscl_pkg::ROWS; r++)
            begin
                if (kscl_pkg::ROW_IDX_W'(r) == row_after)
                begin
                    row_pins_next[r] = 1'b0;
                end
            end
        end

        // Stable when every history entry matches the new matrix
        stable = 1'b1;
        for (int i = 0; i < kscl_pkg::HIST_N; i++)
        begin
            if (hist_reg[i] != key_matrix_next)
            begin
                stable = 1'b0;
            end
        end

        rearm_now = rearmed_reg || (key_matrix_next == '0);
        taken     = rearm_now && stable && (he_inc >= lockout_time);

        hold_elapsed_next = taken ? '0 : he_inc;
        rearmed_next      = taken ? 1'b0 : rearm_now;
    end

    assign push_entry.row_pins = row_pins_next;
    assign push_entry.matrix   = key_matrix_next;
    assign push_entry.taken    = taken;

    // Advance scanner state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_elapsed_reg <= '0;
            hold_elapsed_reg <= '0;
            scan_row_reg     <= '0;
            row_pins_reg     <= '1;
            key_matrix_reg   <= '0;
            rearmed_reg      <= 1'b1;
            for (int i = 0; i < kscl_pkg::HIST_N; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            scan_elapsed_reg <= scan_elapsed_next;
            hold_elapsed_reg <= hold_elapsed_next;
            scan_row_reg     <= scan_row_next;
            row_pins_reg     <= row_pins_next;
            key_matrix_reg   <= key_matrix_next;
            rearmed_reg      <= rearmed_next;
            hist_reg[0]      <= key_matrix_next;
            for (int i = 1; i < kscl_pkg::HIST_N; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/kscl_queue.sv =====
// Two-entry queue between the scanner and the lock sequencer
`default_nettype none

module kscl_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  kscl_pkg::tick_entry_t      push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       pop_valid,
    output kscl_pkg::tick_entry_t      pop_entry
);

    kscl_pkg::tick_entry_t slot_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Hold entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kscl_back.sv =====
// Lock sequencer and registered result stage
`default_nettype none

module kscl_back
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  kscl_pkg::tick_entry_t                q_entry,
    output logic                                 pop,
    input  wire logic [kscl_pkg::CODE_W-1:0]     code_keys,
    input  wire logic [kscl_pkg::KEY_IDX_W-1:0]  clear_key,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [kscl_pkg::ROW_OUT_W-1:0]       row_drive_n,
    output logic [kscl_pkg::KEYS_OUT_W-1:0]      keys_now,
    output logic [kscl_pkg::POS_OUT_W-1:0]       code_position,
    output logic                                 unlocked,
    output logic                                 press_taken
);

    logic                          out_valid_reg;
    logic [kscl_pkg::ROWS-1:0]     row_pins_reg;
    logic [kscl_pkg::KEY_BITS-1:0] matrix_reg;
    logic                          taken_reg;
    logic [kscl_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          unlock_reg, unlock_next;

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    // Evaluate an accepted pattern against the code
    always_comb
    begin
        logic [kscl_pkg::CODE_SLOTS*kscl_pkg::KEY_IDX_W-1:0] code_ext;
        logic [kscl_pkg::KEY_IDX_W-1:0]                      want_idx;
        logic [kscl_pkg::KEY_BITS-1:0]                       want_bit;
        logic [kscl_pkg::KEY_BITS-1:0]                       clear_bit;
        logic                                                pressed;

        code_ext = (kscl_pkg::CODE_SLOTS * kscl_pkg::KEY_IDX_W)'(code_keys);
        want_idx = '0;
        for (int k = 0; k < kscl_pkg::CODE_SLOTS; k++)
        begin
            if (32'(step_reg) == k)
            begin
                want_idx = code_ext[k*kscl_pkg::KEY_IDX_W +: kscl_pkg::KEY_IDX_W];
            end
        end
        want_bit  = (32'(want_idx) < kscl_pkg::KEY_BITS)
                    ? (kscl_pkg::KEY_BITS'(1) << want_idx) : '0;
        clear_bit = (32'(clear_key) < kscl_pkg::KEY_BITS)
                    ? (kscl_pkg::KEY_BITS'(1) << clear_key) : '0;
        pressed   = (q_entry.matrix != '0);

        step_next   = step_reg;
        unlock_next = unlock_reg;
        if (q_entry.taken)
        begin
            if (step_reg < kscl_pkg::STEP_CORRECT)
            begin
                if (pressed && q_entry.matrix == want_bit)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg + 1'b1 == kscl_pkg::STEP_CORRECT)
                    begin
                        unlock_next = 1'b1;
                    end
                end
                else if (pressed)
                begin
                    step_next = kscl_pkg::STEP_ERROR;
                end
            end
            // Clear key overrides the step result
            if (pressed && q_entry.matrix == clear_bit)
            begin
                step_next   = '0;
                unlock_next = 1'b0;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            row_pins_reg <= q_entry.row_pins;
            matrix_reg   <= q_entry.matrix;
            taken_reg    <= q_entry.taken;
        end
    end

    // Advance lock state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            unlock_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= step_next;
                unlock_reg    <= unlock_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign row_drive_n   = kscl_pkg::ROW_OUT_W'(row_pins_reg);
    assign keys_now      = kscl_pkg::KEYS_OUT_W'(matrix_reg);
    assign code_position = kscl_pkg::POS_OUT_W'(step_reg);
    assign unlocked      = unlock_reg;
    assign press_taken   = taken_reg;

    // Step never runs past the error code
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= kscl_pkg::STEP_ERROR)
        else $error("lock step beyond error code");

    // Unlock level tracks the correct state exactly
    a_unlock_correct: assert property (@(posedge clk) disable iff (!rst_n)
        unlock_reg == (step_reg == kscl_pkg::STEP_CORRECT))
        else $error("unlock level disagrees with lock step");

    // Lock state moves only when an entry leaves the queue
    a_lock_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> ($stable(step_reg) && $stable(unlock_reg)))
        else $error("lock state changed without a queue entry");

endmodule

`default_nettype wire
